/* design/qeps_pkg.sv */
// ----------------------------------------------------------------------------
// qeps_pkg
// Shared types and constants for the quadrature encoder period speed block.
// ----------------------------------------------------------------------------
`default_nettype none

package qeps_pkg;

   localparam int TIME_WIDTH_DEFAULT  = 32;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam int SCALE_WIDTH = 32;
   localparam int POS_WIDTH   = 32;
   localparam int SPEED_WIDTH = 33;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 32'd13994000;
   localparam logic [SCALE_WIDTH-1:0] SPEED_SAT   = 32'hFFFF_FFFF;

   // one quotient bit per divider step
   localparam int DIV_STEPS       = SCALE_WIDTH;
   localparam int STEP_CNT_WIDTH  = $clog2(DIV_STEPS);
   localparam logic [STEP_CNT_WIDTH-1:0] STEP_LAST = STEP_CNT_WIDTH'(DIV_STEPS - 1);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_SPEED_SCALE = 1'b0,
      REG_INVERT_DIR  = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DIV   = 3'b010,
      ST_WRITE = 3'b100
   } state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

/* design/qeps_if.sv */
// ----------------------------------------------------------------------------
// qeps interfaces
// Valid/ready channels for encoder samples, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface qeps_req_if;
   logic valid;
   logic ready;
   logic phase_a;
   logic phase_b;
   modport source (output valid, output phase_a, output phase_b, input ready);
   modport sink   (input valid, input phase_a, input phase_b, output ready);
endinterface

interface qeps_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] position_count;
   logic signed [32:0] speed_mrad;
   logic               just_reversed;
   modport source (output valid, output position_count, output speed_mrad,
                   output just_reversed, input ready);
   modport sink   (input valid, input position_count, input speed_mrad,
                   input just_reversed, output ready);
endinterface

interface qeps_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/qeps_ctrl.sv */
// ----------------------------------------------------------------------------
// qeps_ctrl
// Sequencer: takes a request, runs the divider steps, hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module qeps_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  qeps_pkg::status_type status,
   output qeps_pkg::cmd_type    cmd
);
   import qeps_pkg::*;

   state_type                 state_ff, state_in;
   logic [STEP_CNT_WIDTH-1:0] step_ff, step_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      req_ready    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.div_step = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               step_in    = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

/* design/qeps_dp.sv */
// ----------------------------------------------------------------------------
// qeps_dp
// Encoder state, period selection, restoring divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qeps_dp #(
   parameter int TIME_WIDTH  = qeps_pkg::TIME_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = qeps_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  qeps_pkg::cmd_type                      cmd,
   output qeps_pkg::status_type                   status,
   input  wire                                    csr_valid,
   input  wire  [qeps_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire  [qeps_pkg::CSR_DATA_WIDTH-1:0]    csr_data,
   input  wire                                    phase_a,
   input  wire                                    phase_b,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic signed [qeps_pkg::POS_WIDTH-1:0]   position_count,
   output logic signed [qeps_pkg::SPEED_WIDTH-1:0] speed_mrad,
   output logic                                   just_reversed
);
   import qeps_pkg::*;

   // configuration
   logic [SCALE_WIDTH-1:0] scale_ff;
   logic                   invert_ff;

   // encoder state
   logic [TIME_WIDTH-1:0]  time_now_ff, time_now_in;
   logic [TIME_WIDTH-1:0]  last_edge_ff, last_edge_in;
   logic [TIME_WIDTH-1:0]  prev_edge_ff, prev_edge_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0]             motion_ff, motion_in;
   logic                   last_a_ff;

   // divider
   logic [TIME_WIDTH-1:0]  divisor_ff, divisor_in;
   logic                   zero_ff;
   logic [TIME_WIDTH-1:0]  rem_ff, rem_in;
   logic [SCALE_WIDTH-1:0] quo_ff, quo_in;
   logic [TIME_WIDTH:0]    rem_shift;
   logic [TIME_WIDTH:0]    rem_diff;

   // result register
   logic                          rsp_valid_ff;
   logic signed [POS_WIDTH-1:0]   pos_ff;
   logic signed [SPEED_WIDTH-1:0] speed_ff;
   logic                          rev_ff;

   logic                   is_edge, down, backward;
   logic [TIME_WIDTH-1:0]  period, since;
   logic [SCALE_WIDTH-1:0] mag;
   logic [SPEED_WIDTH-1:0] mag_ext;
   logic [POS_WIDTH-1:0]   count_32;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_RESET;
         invert_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_SPEED_SCALE: scale_ff  <= csr_data[SCALE_WIDTH-1:0];
            REG_INVERT_DIR:  invert_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // edge handling and period selection
   always_comb begin
      is_edge      = phase_a != last_a_ff;
      down         = (phase_a ^ phase_b) ^ invert_ff;
      backward     = motion_ff[0];
      prev_edge_in = prev_edge_ff;
      last_edge_in = last_edge_ff;
      count_in     = count_ff;
      motion_in    = motion_ff;
      if (is_edge) begin
         prev_edge_in = last_edge_ff;
         last_edge_in = time_now_ff;
         if (down) begin
            count_in  = count_ff - 1'b1;
            motion_in = backward ? 2'b01 : 2'b11;
         end else begin
            count_in  = count_ff + 1'b1;
            motion_in = backward ? 2'b10 : 2'b00;
         end
      end
      time_now_in = time_now_ff + 1'b1;
      period      = last_edge_in - prev_edge_in;
      since       = time_now_ff - last_edge_in;
      divisor_in  = (period > since) ? period : since;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_now_ff  <= '0;
         last_edge_ff <= '0;
         prev_edge_ff <= '0;
         count_ff     <= '0;
         motion_ff    <= 2'b00;
         last_a_ff    <= 1'b1;
      end else if (cmd.accept) begin
         time_now_ff  <= time_now_in;
         last_edge_ff <= last_edge_in;
         prev_edge_ff <= prev_edge_in;
         count_ff     <= count_in;
         motion_ff    <= motion_in;
         last_a_ff    <= phase_a;
      end
   end

   // restoring divider, one quotient bit per step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[SCALE_WIDTH-1]};
      rem_diff  = rem_shift - {1'b0, divisor_ff};
      if (!rem_diff[TIME_WIDTH]) begin
         rem_in = rem_diff[TIME_WIDTH-1:0];
         quo_in = {quo_ff[SCALE_WIDTH-2:0], 1'b1};
      end else begin
         rem_in = rem_shift[TIME_WIDTH-1:0];
         quo_in = {quo_ff[SCALE_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         divisor_ff <= divisor_in;
         zero_ff    <= divisor_in == '0;
         rem_ff     <= '0;
         quo_ff     <= scale_ff;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // position count to the output width
   generate
      if (COUNT_WIDTH >= POS_WIDTH) begin : g_pos_trunc
         assign count_32 = count_ff[POS_WIDTH-1:0];
      end else begin : g_pos_ext
         assign count_32 = {{(POS_WIDTH-COUNT_WIDTH){count_ff[COUNT_WIDTH-1]}}, count_ff};
      end
   endgenerate

   always_comb begin
      mag     = zero_ff ? SPEED_SAT : quo_ff;
      mag_ext = {1'b0, mag};
      if (motion_ff[1]) begin
         mag_ext = '0;
      end else if (motion_ff[0]) begin
         mag_ext = '0 - {1'b0, mag};
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         pos_ff   <= count_32;
         speed_ff <= mag_ext;
         rev_ff   <= motion_ff[1];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign position_count = pos_ff;
   assign speed_mrad     = speed_ff;
   assign just_reversed  = rev_ff;

endmodule

`default_nettype wire

/* design/quadrature_encoder_period_speed.sv */
// ----------------------------------------------------------------------------
// quadrature_encoder_period_speed
// Requests are taken one at a time: the 32-step divider must finish and the result
// must be loaded into the result register before the next request is taken.
// The result register lets the next request in while a result waits.
// Reset: synchronous, active high; scale 13994000, phase A high, counts zero.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_encoder_period_speed #(
   parameter int TIME_WIDTH  = qeps_pkg::TIME_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = qeps_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   qeps_req_if.sink    req_ch,
   qeps_rsp_if.source  rsp_ch,
   qeps_csr_if.sink    csr_ch
);
   import qeps_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ch.ready = 1'b1;

   qeps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   qeps_dp #(
      .TIME_WIDTH  (TIME_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_valid      (csr_ch.valid),
      .csr_index      (csr_ch.index),
      .csr_data       (csr_ch.data),
      .phase_a        (req_ch.phase_a),
      .phase_b        (req_ch.phase_b),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .position_count (rsp_ch.position_count),
      .speed_mrad     (rsp_ch.speed_mrad),
      .just_reversed  (rsp_ch.just_reversed)
   );

endmodule

`default_nettype wire

/* tb/qeps_speed_check.sv */
// ----------------------------------------------------------------------------
// qeps_speed_check
// Watches the request, result and register channels of the quadrature encoder
// block. Keeps its own copy of the encoder state and settings, works out the
// position, speed and reversal flag for every accepted request, and compares
// each accepted result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module qeps_speed_check (
   input  wire  clock,
   input  wire  reset,
   qeps_req_if  req_ch,
   qeps_rsp_if  rsp_ch,
   qeps_csr_if  csr_ch,
   output int   fail_count,
   output int   pending
);
   import qeps_pkg::*;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0]   position;
      logic signed [SPEED_WIDTH-1:0] speed;
      logic                          reversed;
   } encoder_result_type;

   encoder_result_type         speed_queue[$];
   logic [SCALE_WIDTH-1:0]     scale;
   logic                       invert;
   logic [31:0]                tick;
   logic [31:0]                newest_edge;
   logic [31:0]                older_edge;
   logic [31:0]                count;
   logic                       backward;
   logic                       reversed;
   logic                       prev_a;
   int                         mismatches;
   int                         outstanding;

   assign fail_count = mismatches;
   assign pending    = outstanding;

   function automatic encoder_result_type advance_encoder(logic a, logic b);
      encoder_result_type r;
      logic [31:0]     now;
      logic [31:0]     period;
      logic [31:0]     since;
      logic [31:0]     span;
      logic [32:0]     mag;
      logic            down;
      now = tick;
      if (a != prev_a) begin
         down        = (a != b) ^ invert;
         older_edge  = newest_edge;
         newest_edge = now;
         if (down) begin
            count    = count - 32'd1;
            reversed = !backward;
            backward = 1'b1;
         end else begin
            count    = count + 32'd1;
            reversed = backward;
            backward = 1'b0;
         end
      end
      prev_a = a;
      r.position = count;
      r.reversed = reversed;
      if (reversed) begin
         r.speed = '0;
      end else begin
         period = newest_edge - older_edge;
         since  = now - newest_edge;
         span   = (period > since) ? period : since;
         mag    = (span == 0) ? {1'b0, SPEED_SAT} : {1'b0, scale / span};
         r.speed = backward ? -mag : mag;
      end
      tick = tick + 32'd1;
      return r;
   endfunction

   always @(posedge clock) begin
      encoder_result_type want;
      if (reset) begin
         scale       = SCALE_RESET;
         invert      = 1'b0;
         tick        = '0;
         newest_edge = '0;
         older_edge  = '0;
         count       = '0;
         backward    = 1'b0;
         reversed    = 1'b0;
         prev_a      = 1'b1;
         mismatches  = 0;
         speed_queue.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (reg_index_type'(csr_ch.index))
               REG_SPEED_SCALE: scale  = csr_ch.data;
               REG_INVERT_DIR:  invert = csr_ch.data[0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (speed_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: pos %0d speed %0d rev %0b",
                           rsp_ch.position_count, rsp_ch.speed_mrad, rsp_ch.just_reversed);
            end else begin
               want = speed_queue.pop_front();
               if (rsp_ch.position_count !== want.position ||
                   rsp_ch.speed_mrad !== want.speed ||
                   rsp_ch.just_reversed !== want.reversed) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected pos %0d speed %0d rev %0b,",
                              want.position, want.speed, want.reversed,
                              " got pos %0d speed %0d rev %0b",
                              rsp_ch.position_count, rsp_ch.speed_mrad, rsp_ch.just_reversed);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            speed_queue.push_back(advance_encoder(req_ch.phase_a, req_ch.phase_b));
      end
      outstanding = speed_queue.size();
   end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives encoder samples into the quadrature encoder block: a short directed
// sequence covering saturation, reversals and both count directions, then
// phases of random quadrature bursts mixed with noise under different scale
// and direction settings. Both channels idle and stall at random. The speed
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import qeps_pkg::*;

   localparam int PHASES     = 6;
   localparam int PHASE_REQS = 255;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   logic [1:0] gray_pos;

   qeps_req_if req_ch ();
   qeps_rsp_if rsp_ch ();
   qeps_csr_if csr_ch ();

   quadrature_encoder_period_speed dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   qeps_speed_check speed_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_sample(logic a, logic b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid   <= 1'b0;
         req_ch.phase_a <= 1'($urandom_range(0, 1));
         req_ch.phase_b <= 1'($urandom_range(0, 1));
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.phase_a <= a;
      req_ch.phase_b <= b;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic apply_settings(logic [31:0] scale, logic inv);
      logic [31:0] inv_word;
      inv_word = $urandom;
      inv_word[0] = inv;
      drain();
      write_reg(REG_SPEED_SCALE, scale);
      write_reg(REG_INVERT_DIR, inv_word);
      csr_ch.valid <= 1'b0;
      csr_ch.data  <= $urandom;
   endtask

   task automatic push_gray();
      push_sample(gray_pos[1], gray_pos[1] ^ gray_pos[0]);
   endtask

   task automatic run_random(int budget);
      int   sent;
      int   steps;
      int   dwell;
      int   n;
      logic dir;
      logic a;
      logic b;
      sent = 0;
      dir  = 1'($urandom_range(0, 1));
      while (sent < budget) begin
         if ($urandom_range(0, 99) < 80) begin
            steps = $urandom_range(4, 30);
            dwell = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
            for (int i = 0; i < steps && sent < budget; i++) begin
               if ($urandom_range(0, 9) == 0) dir = !dir;
               gray_pos = dir ? gray_pos + 2'd1 : gray_pos - 2'd1;
               for (int k = 0; k < dwell && sent < budget; k++) begin
                  push_gray();
                  sent++;
               end
            end
         end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n && sent < budget; i++) begin
               a = 1'($urandom_range(0, 1));
               b = 1'($urandom_range(0, 1));
               gray_pos = {a, a ^ b};
               push_sample(a, b);
               sent++;
            end
         end
      end
   endtask

   // receiver stalls: runs of ready, occasional long stretches with none
   initial begin
      int n;
      rsp_ch.ready = 1'b0;
      forever begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
         rsp_ch.ready <= 1'b1;
         repeat (n) @(negedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
      end
   end

   initial begin
      logic [31:0] scales [PHASES];
      logic        invs   [PHASES];
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.phase_a = 1'b1;
      req_ch.phase_b = 1'b1;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = REG_SPEED_SCALE;
      csr_ch.data    = '0;
      gray_pos       = 2'd2;
      scales = '{32'hFFFF_FFFF, 32'd0, SCALE_RESET, $urandom, 32'd1, $urandom};
      invs   = '{1'b1, 1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b0, 1'b1};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // edge at the first tick, saturated speed
      push_sample(1'b0, 1'b0);
      push_sample(1'b0, 1'b0);
      push_sample(1'b1, 1'b1);
      push_sample(1'b1, 1'b0);
      // reversal to counting down, then steady down
      push_sample(1'b0, 1'b1);
      push_sample(1'b0, 1'b1);
      push_sample(1'b1, 1'b0);
      push_sample(1'b1, 1'b1);
      push_sample(1'b0, 1'b1);
      // reversal back up, then edges on consecutive ticks
      push_sample(1'b1, 1'b1);
      push_sample(1'b0, 1'b0);
      push_sample(1'b1, 1'b1);
      push_sample(1'b0, 1'b0);
      push_sample(1'b0, 1'b1);
      push_sample(1'b0, 1'b1);
      push_sample(1'b0, 1'b1);
      push_sample(1'b1, 1'b1);
      gray_pos = 2'd2;

      for (int p = 0; p < PHASES; p++) begin
         apply_settings(scales[p], invs[p]);
         run_random(PHASE_REQS);
      end

      drain();
      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
